// ===== design/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// sta_pkg
// Shared constants, request codes and the control bundle of the slot chain.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W    = 3;
  localparam int IDX_IN_W = 10;
  localparam int VAL_IN_W = 32;
  localparam int STAT_W   = 3;
  localparam int RIDX_W   = 8;
  localparam int SIZE_O_W = 9;
  localparam int STEP_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;

  localparam logic [REQ_W-1:0] OP_PUTF = 3'd0;
  localparam logic [REQ_W-1:0] OP_PUTI = 3'd1;
  localparam logic [REQ_W-1:0] OP_GET  = 3'd2;
  localparam logic [REQ_W-1:0] OP_REM  = 3'd3;
  localparam logic [REQ_W-1:0] OP_MARK = 3'd4;
  localparam logic [REQ_W-1:0] OP_FIND = 3'd5;
  localparam logic [REQ_W-1:0] OP_CLR  = 3'd6;
  localparam logic [REQ_W-1:0] OP_NOP  = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd1;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_USED     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GROW_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW_DOUBLE = 1'd1;

  typedef struct packed {
    logic             valid;
    logic [REQ_W-1:0] op;
    logic             hit;
    logic             hused;
  } ctl_t;

endpackage

// ===== design/sta_if.sv =====
// ----------------------------------------------------------------------------
// sta_req_if / sta_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface sta_req_if;
  logic                         valid;
  logic                         ready;
  logic [sta_pkg::REQ_W-1:0]    req_type;
  logic [sta_pkg::IDX_IN_W-1:0] slot_index;
  logic [sta_pkg::VAL_IN_W-1:0] item_value;
  modport source (output valid, req_type, slot_index, item_value, input ready);
  modport sink (input valid, req_type, slot_index, item_value, output ready);
endinterface

interface sta_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sta_pkg::STAT_W-1:0]   status;
  logic [sta_pkg::RIDX_W-1:0]   result_index;
  logic [sta_pkg::VAL_IN_W-1:0] result_value;
  logic [sta_pkg::SIZE_O_W-1:0] logical_size;
  logic [sta_pkg::SIZE_O_W-1:0] used_total;
  modport source (output valid, status, result_index, result_value, logical_size,
                  used_total, input ready);
  modport sink (input valid, status, result_index, result_value, logical_size,
                used_total, output ready);
endinterface

// ===== design/sta_cell.sv =====
// ----------------------------------------------------------------------------
// sta_cell
// One slot of the table: value and used bit; acts on the item passing by.
// ----------------------------------------------------------------------------
module sta_cell #(
  parameter int DATA_WIDTH = sta_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = 8,
  parameter int CELL_INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sta_pkg::ctl_t         ctl_in,
  input  logic [IDX_W-1:0]      idx_in,
  input  logic [DATA_WIDTH-1:0] val_in,
  input  logic [IDX_W-1:0]      hidx_in,
  input  logic [DATA_WIDTH-1:0] hval_in,
  output sta_pkg::ctl_t         ctl_out,
  output logic [IDX_W-1:0]      idx_out,
  output logic [DATA_WIDTH-1:0] val_out,
  output logic [IDX_W-1:0]      hidx_out,
  output logic [DATA_WIDTH-1:0] hval_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic                  used;
  logic                  used_next;
  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] value_next;
  sta_pkg::ctl_t         ctl_next;
  logic [IDX_W-1:0]      hidx_next;
  logic [DATA_WIDTH-1:0] hval_next;
  logic                  here;

  always_comb begin
    here       = (idx_in == MY_IDX);
    ctl_next   = ctl_in;
    hidx_next  = hidx_in;
    hval_next  = hval_in;
    used_next  = used;
    value_next = value;
    if (ctl_in.valid) begin
      case (ctl_in.op)
        sta_pkg::OP_PUTF: begin
          if (!ctl_in.hit && !used) begin
            used_next    = 1'b1;
            value_next   = val_in;
            ctl_next.hit = 1'b1;
            hidx_next    = MY_IDX;
          end
        end
        sta_pkg::OP_PUTI: begin
          if (here) begin
            ctl_next.hused = used;
            ctl_next.hit   = 1'b1;
            used_next      = 1'b1;
            value_next     = val_in;
          end
        end
        sta_pkg::OP_GET: begin
          if (here) begin
            ctl_next.hit = used;
            hval_next    = value;
          end
        end
        sta_pkg::OP_REM: begin
          if (here) begin
            ctl_next.hit = used;
            used_next    = 1'b0;
          end
        end
        sta_pkg::OP_MARK: begin
          if (here) begin
            ctl_next.hused = used;
            ctl_next.hit   = 1'b1;
            used_next      = 1'b1;
          end
        end
        sta_pkg::OP_FIND: begin
          if (!ctl_in.hit && used && value == val_in) begin
            ctl_next.hit = 1'b1;
            hidx_next    = MY_IDX;
          end
        end
        sta_pkg::OP_CLR: begin
          used_next  = 1'b0;
          value_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      used          <= used_next;
      ctl_out.valid <= ctl_next.valid;
    end
    value          <= value_next;
    ctl_out.op     <= ctl_next.op;
    ctl_out.hit    <= ctl_next.hit;
    ctl_out.hused  <= ctl_next.hused;
    idx_out        <= idx_in;
    val_out        <= val_in;
    hidx_out       <= hidx_next;
    hval_out       <= hval_next;
  end

endmodule

// ===== design/slot_table_allocator.sv =====
// ----------------------------------------------------------------------------
// slot_table_allocator
// Slot table with used bits and a growing logical size, one cell per slot.
// ----------------------------------------------------------------------------
// channel | dir | handshake    | payload
// req     | in  | valid/ready  | req_type, slot_index, item_value
// rsp     | out | valid/ready  | status, result_index, result_value, sizes
// cfg     | in  | cfg_we       | cfg_index, cfg_wdata
//
// Each item sweeps the whole chain: the result passes the input register,
// the cell register of every slot, the sweep result register and the
// output register before it is valid. Growth for a put at an index runs
// alongside the sweep and does not delay the result. One item at a time.
// Reset empties the table at once. The result is held until taken; no new
// item is taken meanwhile.
// ----------------------------------------------------------------------------
module slot_table_allocator #(
  parameter int CAPACITY   = sta_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = sta_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sta_req_if.sink                        req,
  sta_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [sta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sta_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int SW  = $clog2(CAPACITY + 1);
  localparam int GW  = ((SW > sta_pkg::STEP_W) ? SW : sta_pkg::STEP_W) + 1;
  localparam int O_RW = sta_pkg::RIDX_W;
  localparam int O_VW = sta_pkg::VAL_IN_W;
  localparam int O_SW = sta_pkg::SIZE_O_W;
  localparam logic [GW-1:0] CAP_G = GW'(CAPACITY);
  localparam logic [SW-1:0] ONE_S = SW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]                       state;
  logic [sta_pkg::STEP_W-1:0]       grow_step;
  logic                             grow_double;
  logic [SW-1:0]                    size_now;
  logic [SW-1:0]                    used_count;
  logic [sta_pkg::REQ_W-1:0]        op_q;
  logic [sta_pkg::STAT_W-1:0]       pre_stat;
  logic [IW-1:0]                    idx_q;
  logic                             swept;
  sta_pkg::ctl_t                    res_ctl;
  logic [IW-1:0]                    res_hidx;
  logic [DATA_WIDTH-1:0]            res_hval;

  sta_pkg::ctl_t                    ctl_c  [CAPACITY+1];
  logic [IW-1:0]                    idx_c  [CAPACITY+1];
  logic [DATA_WIDTH-1:0]            val_c  [CAPACITY+1];
  logic [IW-1:0]                    hidx_c [CAPACITY+1];
  logic [DATA_WIDTH-1:0]            hval_c [CAPACITY+1];

  logic                             acc;
  logic [sta_pkg::REQ_W-1:0]        op_in;
  logic [sta_pkg::STAT_W-1:0]       stat_in;
  logic [IW-1:0]                    idx_in;
  logic [DATA_WIDTH-1:0]            val_in;
  logic [GW-1:0]                    grown_g;
  logic [SW-1:0]                    grown;
  logic                             grow_pending;
  logic                             done;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);

  always_comb begin
    idx_in  = IW'(req.slot_index);
    val_in  = DATA_WIDTH'(req.item_value);
    op_in   = req.req_type;
    stat_in = sta_pkg::ST_OK;
    unique case (req.req_type)
      sta_pkg::OP_PUTI: begin
        if (32'(req.slot_index) >= CAPACITY) begin
          op_in   = sta_pkg::OP_NOP;
          stat_in = sta_pkg::ST_NO_ROOM;
        end
      end
      sta_pkg::OP_GET, sta_pkg::OP_REM, sta_pkg::OP_MARK: begin
        if (32'(req.slot_index) >= 32'(size_now)) begin
          op_in   = sta_pkg::OP_NOP;
          stat_in = sta_pkg::ST_INVALID;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (grow_double) begin
      grown_g = (size_now == '0) ? GW'(1) : (GW'(size_now) << 1);
    end else begin
      grown_g = GW'(size_now) + ((grow_step == '0) ? GW'(1) : GW'(grow_step));
    end
    grown = (grown_g > CAP_G) ? SW'(CAPACITY) : grown_g[SW-1:0];
  end

  assign grow_pending = (op_q == sta_pkg::OP_PUTI) && (32'(idx_q) >= 32'(size_now));
  assign done         = swept && !grow_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      grow_step   <= sta_pkg::STEP_W'(1);
      grow_double <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sta_pkg::CFG_GROW_STEP:   grow_step   <= cfg_wdata;
        sta_pkg::CFG_GROW_DOUBLE: grow_double <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0].valid <= 1'b0;
    end else begin
      ctl_c[0].valid <= acc;
    end
    ctl_c[0].op    <= op_in;
    ctl_c[0].hit   <= 1'b0;
    ctl_c[0].hused <= 1'b0;
    idx_c[0]       <= idx_in;
    val_c[0]       <= val_in;
    hidx_c[0]      <= '0;
    hval_c[0]      <= '0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sta_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IW),
      .CELL_INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_c[i]),
      .idx_in   (idx_c[i]),
      .val_in   (val_c[i]),
      .hidx_in  (hidx_c[i]),
      .hval_in  (hval_c[i]),
      .ctl_out  (ctl_c[i+1]),
      .idx_out  (idx_c[i+1]),
      .val_out  (val_c[i+1]),
      .hidx_out (hidx_c[i+1]),
      .hval_out (hval_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      size_now   <= '0;
      used_count <= '0;
      swept      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            state    <= S_RUN;
            op_q     <= op_in;
            pre_stat <= stat_in;
            idx_q    <= idx_in;
            swept    <= 1'b0;
          end
        end
        S_RUN: begin
          if (ctl_c[CAPACITY].valid) begin
            swept    <= 1'b1;
            res_ctl  <= ctl_c[CAPACITY];
            res_hidx <= hidx_c[CAPACITY];
            res_hval <= hval_c[CAPACITY];
          end
          if (grow_pending) begin
            size_now <= grown;
          end else if (done) begin
            state            <= S_OUT;
            rsp.status       <= pre_stat;
            rsp.result_index <= '0;
            rsp.result_value <= '0;
            rsp.logical_size <= O_SW'(size_now);
            rsp.used_total   <= O_SW'(used_count);
            unique case (op_q)
              sta_pkg::OP_PUTF: begin
                if (res_ctl.hit) begin
                  rsp.result_index <= O_RW'(res_hidx);
                  used_count       <= used_count + ONE_S;
                  rsp.used_total   <= O_SW'(used_count + ONE_S);
                  if (SW'(res_hidx) == size_now) begin
                    size_now         <= grown;
                    rsp.logical_size <= O_SW'(grown);
                  end
                end else begin
                  rsp.status <= sta_pkg::ST_NO_ROOM;
                end
              end
              sta_pkg::OP_PUTI: begin
                rsp.result_index <= O_RW'(idx_q);
                if (!res_ctl.hused) begin
                  used_count     <= used_count + ONE_S;
                  rsp.used_total <= O_SW'(used_count + ONE_S);
                end
              end
              sta_pkg::OP_GET: begin
                if (res_ctl.hit) begin
                  rsp.result_value <= O_VW'(res_hval);
                end else begin
                  rsp.status <= sta_pkg::ST_INVALID;
                end
              end
              sta_pkg::OP_REM: begin
                if (res_ctl.hit) begin
                  used_count     <= used_count - ONE_S;
                  rsp.used_total <= O_SW'(used_count - ONE_S);
                end else begin
                  rsp.status <= sta_pkg::ST_INVALID;
                end
              end
              sta_pkg::OP_MARK: begin
                if (res_ctl.hused) begin
                  rsp.status <= sta_pkg::ST_USED;
                end else begin
                  used_count     <= used_count + ONE_S;
                  rsp.used_total <= O_SW'(used_count + ONE_S);
                end
              end
              sta_pkg::OP_FIND: begin
                if (res_ctl.hit) begin
                  rsp.result_index <= O_RW'(res_hidx);
                end else begin
                  rsp.status <= sta_pkg::ST_NOTFOUND;
                end
              end
              sta_pkg::OP_CLR: begin
                size_now         <= '0;
                used_count       <= '0;
                rsp.logical_size <= '0;
                rsp.used_total   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_le_size: assert property (@(posedge clk) disable iff (rst)
    used_count <= size_now) else $error("used count above logical size");
  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    32'(size_now) <= CAPACITY) else $error("logical size above capacity");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    acc |=> !req.ready) else $error("second item taken while busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("input open while result pending");

endmodule
